// ===== hw/rtl/prr_pkg.sv =====
// ----------------------------------------------------------------------------
// prr_pkg
// Shared types, constants and helpers of the polyphase rational resampler.
// ----------------------------------------------------------------------------
package prr_pkg;

    // Default parameter values of the top level.
    localparam int DEF_MAX_TAPS    = 256;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed field widths.
    localparam int COEF_W      = 16;
    localparam int COEF_IDX_W  = 8;
    localparam int FACTOR_W    = 7;
    localparam int FACTOR_MAX  = 64;
    localparam int TAP_CNT_W   = 9;
    localparam int PHASE_W     = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int ROUND_SHIFT = 15;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_UP_FACTOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 2'd2;

    // Item command codes.
    localparam logic CMD_SAMPLE    = 1'b0;
    localparam logic CMD_COEF_WRITE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MAC,
        S_DRAIN,
        S_ROUND,
        S_EMIT
    } t_back_state;

    typedef struct packed {
        logic [FACTOR_W-1:0] up;
        logic [FACTOR_W-1:0] down;
    } t_cfg;

    typedef struct packed {
        logic [COEF_IDX_W-1:0]    index;
        logic signed [COEF_W-1:0] value;
    } t_coef_wr;

    // A factor of zero acts as one, anything above the maximum as the maximum.
    function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] f);
        logic [FACTOR_W-1:0] r;
        if (f == '0) begin
            r = FACTOR_W'(1);
        end else if (f > FACTOR_W'(FACTOR_MAX)) begin
            r = FACTOR_W'(FACTOR_MAX);
        end else begin
            r = f;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/polyphase_rational_resampler.sv =====
// ----------------------------------------------------------------------------
// polyphase_rational_resampler
// Rational up/down resampler built around one shared multiply-accumulate.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the input channel (i_in_valid / o_in_stall). An item
// with cmd set loads one Q1.15 coefficient and gives no result; an item with
// cmd clear pushes one sample into the delay line and gives every output whose
// newest input is that sample, from zero up to ceil(up/down) results. Results
// leave on the output channel (o_out_valid / i_out_stall) and the final result
// of a sample carries o_last. The user must write factors and tap count
// through the configuration port only while the block is idle; the block
// itself does not enforce this.
// The single MAC handles one tap per cycle and has a three-stage read,
// multiply and accumulate pipeline that drains before rounding.
// Reset clears the control state; a fill count makes never-written delay line
// slots read as zero, so no clearing pass is needed. Coefficients are
// undefined until loaded. When the receiver stalls, the result waits in the
// output register, the MAC waits, and a two-entry queue keeps taking items.
// ----------------------------------------------------------------------------
module polyphase_rational_resampler import prr_pkg::*; #(
    parameter int MAX_TAPS    = DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration port.
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic [COEF_IDX_W-1:0]         i_coef_index,
    input  logic signed [COEF_W-1:0]      i_coef_value,
    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_last,
    output logic                          o_clipped
);

    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam int RESET_TAPS = (MAX_TAPS < 256) ? MAX_TAPS : 256;

    // Factors and tap count are stored already clamped to their legal ranges,
    // so the back end never sees a zero factor or a tap count beyond the RAM.
    t_cfg          r_cfg;
    logic [TW-1:0] r_taps;
    logic [31:0]   taps_wr;
    logic [TW-1:0] taps_clamped;

    logic                   q_valid;
    logic                   q_pop;
    logic                   q_cmd;
    logic [SAMPLE_BITS-1:0] q_sample;
    t_coef_wr               q_coef;

    always_comb begin
        taps_wr = 32'(i_cfg_data[TAP_CNT_W-1:0]);
        if (taps_wr == '0) begin
            taps_clamped = TW'(1);
        end else if (taps_wr > 32'(MAX_TAPS)) begin
            taps_clamped = TW'(MAX_TAPS);
        end else begin
            taps_clamped = TW'(taps_wr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up   <= FACTOR_W'(1);
            r_cfg.down <= FACTOR_W'(1);
            r_taps     <= TW'(RESET_TAPS);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_UP_FACTOR: begin
                    r_cfg.up <= clamp_factor(i_cfg_data[FACTOR_W-1:0]);
                end
                REG_DOWN_FACTOR: begin
                    r_cfg.down <= clamp_factor(i_cfg_data[FACTOR_W-1:0]);
                end
                REG_TAP_COUNT: begin
                    r_taps <= taps_clamped;
                end
                default: begin
                    r_taps <= r_taps;
                end
            endcase
        end
    end

    prr_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_sample_in  (i_sample_in),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .o_q_valid    (q_valid),
        .i_q_pop      (q_pop),
        .o_q_cmd      (q_cmd),
        .o_q_sample   (q_sample),
        .o_q_coef     (q_coef)
    );

    prr_back #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_taps       (r_taps),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_q_cmd      (q_cmd),
        .i_q_sample   (q_sample),
        .i_q_coef     (q_coef),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_last       (o_last),
        .o_clipped    (o_clipped)
    );

    // The stored factors always stay within one to the maximum factor.
    a_factor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cfg.up != '0) && (r_cfg.up <= FACTOR_W'(FACTOR_MAX)) &&
        (r_cfg.down != '0) && (r_cfg.down <= FACTOR_W'(FACTOR_MAX)))
        else $error("resampler factor out of range");

    // The stored tap count never addresses beyond the coefficient RAM.
    a_taps_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_taps != '0) && (r_taps <= TW'(MAX_TAPS)))
        else $error("resampler tap count out of range");

    // No result is offered in the cycle after a reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

endmodule

// ===== hw/rtl/prr_ram.sv =====
// ----------------------------------------------------------------------------
// prr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module prr_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/prr_front.sv =====
// ----------------------------------------------------------------------------
// prr_front
// Input side: accepts items into a short queue that feeds the back end.
// ----------------------------------------------------------------------------
module prr_front import prr_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic [COEF_IDX_W-1:0]         i_coef_index,
    input  logic signed [COEF_W-1:0]      i_coef_value,
    output logic                          o_q_valid,
    input  logic                          i_q_pop,
    output logic                          o_q_cmd,
    output logic signed [SAMPLE_BITS-1:0] o_q_sample,
    output t_coef_wr                      o_q_coef
);

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic                   r_cmd    [QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0] r_sample [QUEUE_DEPTH];
    t_coef_wr               r_coef   [QUEUE_DEPTH];
    logic [QPW-1:0]         r_wptr, n_wptr;
    logic [QPW-1:0]         r_rptr, n_rptr;
    logic [QCW-1:0]         r_count, n_count;
    logic                   push;
    logic                   pop;

    assign o_in_stall = (r_count == QCW'(QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_q_pop && (r_count != '0);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_cmd[r_wptr]    <= i_cmd;
            r_sample[r_wptr] <= i_sample_in;
            r_coef[r_wptr]   <= '{index: i_coef_index, value: i_coef_value};
        end
    end

    assign o_q_valid  = (r_count != '0);
    assign o_q_cmd    = r_cmd[r_rptr];
    assign o_q_sample = r_sample[r_rptr];
    assign o_q_coef   = r_coef[r_rptr];

endmodule

// ===== hw/rtl/prr_back.sv =====
// ----------------------------------------------------------------------------
// prr_back
// Execution side: coefficient loads, delay line updates, one shared MAC that
// walks the taps of each phase, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module prr_back import prr_pkg::*; #(
    parameter int MAX_TAPS    = DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_cfg                                 i_cfg,
    input  logic [$clog2(MAX_TAPS+1)-1:0]        i_taps,
    input  logic                                 i_q_valid,
    output logic                                 o_q_pop,
    input  logic                                 i_q_cmd,
    input  logic signed [SAMPLE_BITS-1:0]        i_q_sample,
    input  t_coef_wr                             i_q_coef,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_sample_out,
    output logic                                 o_last,
    output logic                                 o_clipped
);

    localparam int PW   = $clog2(MAX_TAPS);
    localparam int FW   = $clog2(MAX_TAPS + 1);
    localparam int KW   = $clog2(MAX_TAPS + FACTOR_MAX + 1);
    localparam int PRW  = COEF_W + SAMPLE_BITS;
    localparam int ACCW = PRW + $clog2(MAX_TAPS);
    localparam int RW   = ACCW + 1 - ROUND_SHIFT;

    localparam logic signed [RW-1:0] SMAX = RW'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RW-1:0] SMIN = ~SMAX;
    localparam logic [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    t_back_state r_state, n_state;

    logic [PW-1:0]      r_newest;
    logic [FW-1:0]      r_fill;
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] r_p;
    logic [KW-1:0]      r_k;
    logic [PW-1:0]      r_pos;
    logic [FW-1:0]      r_j;
    logic               r_v1, r_z1, r_v2;
    logic signed [PRW-1:0]  r_prod;
    logic signed [ACCW-1:0] r_acc;
    logic [SAMPLE_BITS-1:0] r_res;
    logic               r_res_clip;
    logic               r_res_last;

    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_sample;
    logic                   r_out_last;
    logic                   r_out_clip;

    logic [PW-1:0]          newest_next;
    logic                   start_sample;
    logic                   coef_we;
    logic                   dl_we;
    logic                   issue;
    logic                   more_taps;
    logic                   out_free;
    logic [COEF_W-1:0]      coef_rdata;
    logic [SAMPLE_BITS-1:0] dl_rdata;
    logic signed [ACCW:0]   rsum;
    logic signed [RW-1:0]   rsh;

    assign newest_next = (r_newest == PW'(MAX_TAPS - 1)) ? '0 : r_newest + 1'b1;
    assign more_taps   = (r_k < KW'(i_taps));
    assign out_free    = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && (i_q_cmd == CMD_SAMPLE)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = (r_p < i_cfg.up) ? S_MAC : S_IDLE;
            end
            S_MAC: begin
                if (!more_taps) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_q_pop      = 1'b0;
        coef_we      = 1'b0;
        dl_we        = 1'b0;
        issue        = 1'b0;
        start_sample = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    if (i_q_cmd == CMD_COEF_WRITE) begin
                        coef_we = (32'(i_q_coef.index) < MAX_TAPS);
                    end else begin
                        dl_we        = 1'b1;
                        start_sample = 1'b1;
                    end
                end
            end
            S_MAC: begin
                issue = more_taps;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    prr_ram #(
        .W     (COEF_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (PW'(i_q_coef.index)),
        .i_wdata (i_q_coef.value),
        .i_raddr (r_k[PW-1:0]),
        .o_rdata (coef_rdata)
    );

    prr_ram #(
        .W     (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (dl_we),
        .i_waddr (newest_next),
        .i_wdata (i_q_sample),
        .i_raddr (r_pos),
        .o_rdata (dl_rdata)
    );

    // Rounding: add one half, then an arithmetic shift floors the value.
    always_comb begin
        rsum = $signed({r_acc[ACCW-1], r_acc}) + $signed((ACCW+1)'(2 ** (ROUND_SHIFT - 1)));
        rsh  = rsum[ACCW:ROUND_SHIFT];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_newest    <= '0;
            r_fill      <= '0;
            r_phase     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            if (start_sample) begin
                r_newest <= newest_next;
                if (r_fill != FW'(MAX_TAPS)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if ((r_state == S_CHECK) && !(r_p < i_cfg.up)) begin
                r_phase <= r_p - i_cfg.up;
            end
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (start_sample) begin
            r_p <= r_phase;
        end
        if (r_state == S_CHECK) begin
            r_k   <= KW'(r_p);
            r_pos <= r_newest;
            r_j   <= '0;
            r_acc <= '0;
        end
        if (issue) begin
            r_k   <= r_k + KW'(i_cfg.up);
            r_pos <= (r_pos == '0) ? PW'(MAX_TAPS - 1) : r_pos - 1'b1;
            r_j   <= r_j + 1'b1;
        end
        // Slots not yet filled since reset read as zero.
        r_z1 <= (r_j >= r_fill);
        if (r_v1) begin
            if (r_z1) begin
                r_prod <= '0;
            end else begin
                r_prod <= $signed(coef_rdata) * $signed(dl_rdata);
            end
        end
        if (r_v2) begin
            r_acc <= r_acc + {{(ACCW-PRW){r_prod[PRW-1]}}, r_prod};
        end
        if (r_state == S_ROUND) begin
            if (rsh > SMAX) begin
                r_res      <= SAT_HI;
                r_res_clip <= 1'b1;
            end else if (rsh < SMIN) begin
                r_res      <= SAT_LO;
                r_res_clip <= 1'b1;
            end else begin
                r_res      <= rsh[SAMPLE_BITS-1:0];
                r_res_clip <= 1'b0;
            end
            r_res_last <= ((8'(r_p) + 8'(i_cfg.down)) >= 8'(i_cfg.up));
        end
        if ((r_state == S_EMIT) && out_free) begin
            r_out_sample <= r_res;
            r_out_last   <= r_res_last;
            r_out_clip   <= r_res_clip;
            r_p          <= r_p + i_cfg.down;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_last       = r_out_last;
    assign o_clipped    = r_out_clip;

endmodule

// ===== tb/sv/polyphase_rational_resampler_tb.sv =====
// ----------------------------------------------------------------------------
// polyphase_rational_resampler_tb
// Self-checking testbench. A short table of directed items is run at tap count
// one, with the expected output typed in where it is obvious. Then all taps
// are loaded, and random sample and coefficient items run under a series of
// factor and tap count settings, out-of-range ones among them. A predictor
// in the testbench computes every result and each one is compared field by
// field as it leaves the block. Both channels idle at random, except in one steady phase.
// ----------------------------------------------------------------------------
module polyphase_rational_resampler_tb;
    import prr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = DEF_SAMPLE_BITS;
    localparam int TAPS_MAX = DEF_MAX_TAPS;

    // A sample may still be in the back end after its last result has left,
    // and at the full tap count one result walks up to every tap in the MAC. The
    // settle pause covers that; the watchdog allows for long stall runs too.
    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    // Register index that the block does not decode; a write there does nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam longint OUT_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;

    // One result item as it should leave the block.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       last;
        logic                       clipped;
    } t_resampled;

    // One row of the directed table. Rows with has_typed set carry the output
    // read off by hand; all others are left to the predictor.
    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [COEF_IDX_W-1:0]      coef_index;
        logic signed [COEF_W-1:0]   coef_value;
        logic                       has_typed;
        logic signed [SAMPLE_W-1:0] typed_out;
        logic                       typed_clip;
    } t_stim_row;

    localparam int N_DIRECTED = 15;

    // The directed rows run at the reset factors (one and one) and a tap
    // count of one, so every sample gives one result equal to tap 0 times
    // the sample.
    t_stim_row directed_rows [N_DIRECTED] = '{
        // Tap 0 = -1.0, the most negative coefficient.
        '{CMD_COEF_WRITE, 16'sh0000, 8'd0, 16'sh8000, 1'b0, 16'sh0000, 1'b0},
        '{CMD_SAMPLE, 16'sh7FFF, 8'd0, 16'sh0000, 1'b1, 16'sh8001, 1'b0},
        // Minus one times the most negative sample does not fit and saturates.
        '{CMD_SAMPLE, 16'sh8000, 8'd0, 16'sh0000, 1'b1, 16'sh7FFF, 1'b1},
        '{CMD_SAMPLE, 16'sh0000, 8'd0, 16'sh0000, 1'b1, 16'sh0000, 1'b0},
        '{CMD_SAMPLE, 16'shFFFF, 8'd0, 16'sh0000, 1'b1, 16'sh0001, 1'b0},
        // Tap 0 = 0.5: odd samples land on exact halves, which round upward.
        '{CMD_COEF_WRITE, 16'sh0000, 8'd0, 16'sh4000, 1'b0, 16'sh0000, 1'b0},
        '{CMD_SAMPLE, 16'sh0001, 8'd0, 16'sh0000, 1'b1, 16'sh0001, 1'b0},
        '{CMD_SAMPLE, 16'shFFFF, 8'd0, 16'sh0000, 1'b1, 16'sh0000, 1'b0},
        '{CMD_SAMPLE, 16'sh0003, 8'd0, 16'sh0000, 1'b1, 16'sh0002, 1'b0},
        // The highest index is loaded but lies outside the single tap in use.
        '{CMD_COEF_WRITE, 16'sh0000, 8'd255, 16'sh7FFF, 1'b0, 16'sh0000, 1'b0},
        '{CMD_COEF_WRITE, 16'sh0000, 8'd0, 16'sh7FFF, 1'b0, 16'sh0000, 1'b0},
        '{CMD_SAMPLE, 16'sh7FFF, 8'd0, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{CMD_SAMPLE, 16'sh8000, 8'd0, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{CMD_COEF_WRITE, 16'sh0000, 8'd0, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{CMD_SAMPLE, 16'sh7FFF, 8'd0, 16'sh0000, 1'b1, 16'sh0000, 1'b0}
    };

    // Settings of the random part, raw as written to the port. Zeros act as
    // one, factors above 64 and tap counts above 256 are clamped, and the
    // two top data bits of a factor write are dropped by the block.
    localparam int N_PHASES = 10;
    localparam logic [CFG_DATA_W-1:0] PHASE_UP [N_PHASES] =
        '{9'd3, 9'd0, 9'd1, 9'd64, 9'h1FF, 9'd5, 9'd2, 9'd64, 9'd7, 9'd1};
    localparam logic [CFG_DATA_W-1:0] PHASE_DOWN [N_PHASES] =
        '{9'd2, 9'd0, 9'd7, 9'd1, 9'h1C0, 9'd3, 9'd5, 9'd63, 9'd64, 9'd1};
    localparam logic [CFG_DATA_W-1:0] PHASE_TAPS [N_PHASES] =
        '{9'd48, 9'd0, 9'd200, 9'd256, 9'h1FF, 9'd100, 9'd37, 9'd256, 9'd130, 9'd256};
    localparam int PHASE_ITEMS [N_PHASES] =
        '{4, 3, 5, 2, 2, 12, 4, 2, 3, 2};
    // The phase that runs with no idling on either side.
    localparam int STEADY_PHASE = 5;

    // ------------------------------------------------------------------------
    // Clock, and every input of the block at a known value from time zero.
    // ------------------------------------------------------------------------
    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data   = '0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_stall;
    logic                          i_cmd        = CMD_SAMPLE;
    logic signed [SAMPLE_W-1:0]    i_sample_in  = '0;
    logic [COEF_IDX_W-1:0]         i_coef_index = '0;
    logic signed [COEF_W-1:0]      i_coef_value = '0;
    logic                          o_out_valid;
    logic                          i_out_stall  = 1'b0;
    logic signed [SAMPLE_W-1:0]    o_sample_out;
    logic                          o_last;
    logic                          o_clipped;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    polyphase_rational_resampler dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_sample_in  (i_sample_in),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_last       (o_last),
        .o_clipped    (o_clipped)
    );

    // ------------------------------------------------------------------------
    // Predictor state: its own copy of the registers, taps, delay line and the
    // running phase of the next kept value in the upsampled stream.
    // ------------------------------------------------------------------------
    logic [FACTOR_W-1:0]        up_reg;
    logic [FACTOR_W-1:0]        down_reg;
    logic [TAP_CNT_W-1:0]       taps_reg;
    logic signed [COEF_W-1:0]   tap_mem     [TAPS_MAX];
    logic signed [SAMPLE_W-1:0] sample_hist [TAPS_MAX];
    int unsigned                newest_slot;
    int unsigned                next_phase;

    t_resampled step_results[$];     // results of the item just predicted
    t_resampled pending_outputs[$];  // results the block still owes, oldest first
    t_resampled oldest_output;

    bit no_idle = 1'b0;
    int error_count     = 0;
    int items_accepted  = 0;
    int coef_loads      = 0;
    int results_checked = 0;
    int clipped_seen    = 0;
    int quiet_cycles    = 0;

    // A factor of zero counts as one, anything above 64 as 64.
    function automatic int unsigned effective_factor(input logic [FACTOR_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > FACTOR_MAX) return FACTOR_MAX;
        return raw;
    endfunction

    // Mostly small taps, so that long filters do not always saturate, with
    // a quarter drawn over the whole Q1.15 range.
    function automatic logic signed [COEF_W-1:0] random_coef();
        int v;
        if ($urandom_range(0, 3) == 0) begin
            v = $urandom;
        end else begin
            v = $urandom_range(0, 4095) - 2048;
        end
        return v[COEF_W-1:0];
    endfunction

    // Works out the results of one accepted item into step_results and
    // advances the predictor state.
    task automatic predict_resampled_outputs(
        input logic                       cmd,
        input logic signed [SAMPLE_W-1:0] sample_in,
        input logic [COEF_IDX_W-1:0]      coef_index,
        input logic signed [COEF_W-1:0]   coef_value
    );
        int unsigned us, ds, taps, ph, k, j, slot;
        longint      acc, rounded;
        logic        clip;
        t_resampled  res;
        step_results.delete();
        if (cmd == CMD_COEF_WRITE) begin
            // All 256 indexes exist, so a coefficient write always lands.
            tap_mem[coef_index] = coef_value;
            return;
        end
        newest_slot = (newest_slot + 1) % TAPS_MAX;
        sample_hist[newest_slot] = sample_in;

        us = effective_factor(up_reg);
        ds = effective_factor(down_reg);
        taps = taps_reg;
        if (taps == 0) taps = 1;
        if (taps > TAPS_MAX) taps = TAPS_MAX;

        // Every kept value whose phase falls inside this sample's span of
        // the upsampled stream is computed from the polyphase branch ph.
        ph = next_phase;
        while (ph < us) begin
            acc = 0;
            j = 0;
            for (k = ph; k < taps; k += us) begin
                slot = (newest_slot + TAPS_MAX - j) % TAPS_MAX;
                acc += longint'(tap_mem[k]) * longint'(sample_hist[slot]);
                j++;
            end
            // Round half toward plus infinity, then saturate.
            rounded = (acc + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
            clip = 1'b0;
            if (rounded > OUT_MAX) begin
                rounded = OUT_MAX;
                clip = 1'b1;
            end else if (rounded < OUT_MIN) begin
                rounded = OUT_MIN;
                clip = 1'b1;
            end
            res.sample_out = rounded[SAMPLE_W-1:0];
            res.last       = 1'b0;
            res.clipped    = clip;
            step_results.insert(step_results.size(), res);
            ph += ds;
        end
        next_phase = ph - us;
        if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Driving. Every task below starts and ends at a falling edge, so each
    // input gets at most one assignment per time step.
    // ------------------------------------------------------------------------
    task automatic write_register(
        input logic [CFG_IDX_W-1:0]  index,
        input logic [CFG_DATA_W-1:0] data
    );
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (index)
            REG_UP_FACTOR:   up_reg = data[FACTOR_W-1:0];
            REG_DOWN_FACTOR: down_reg = data[FACTOR_W-1:0];
            REG_TAP_COUNT:   taps_reg = data[TAP_CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offers one item, holds it until the block takes it, and records what it
    // should produce: the typed output when there is one, else the predictor's.
    task automatic send_item(
        input logic                       cmd,
        input logic signed [SAMPLE_W-1:0] sample_in,
        input logic [COEF_IDX_W-1:0]      coef_index,
        input logic signed [COEF_W-1:0]   coef_value,
        input logic                       has_typed,
        input logic signed [SAMPLE_W-1:0] typed_out,
        input logic                       typed_clip
    );
        t_resampled typed_res;
        while (!no_idle && $urandom_range(0, 99) < 24) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_sample_in  <= sample_in;
        i_coef_index <= coef_index;
        i_coef_value <= coef_value;
        do @(posedge i_clk); while (o_in_stall);

        items_accepted++;
        if (cmd == CMD_COEF_WRITE) coef_loads++;
        predict_resampled_outputs(cmd, sample_in, coef_index, coef_value);
        if (has_typed) begin
            typed_res.sample_out = typed_out;
            typed_res.last       = 1'b1;
            typed_res.clipped    = typed_clip;
            pending_outputs.insert(pending_outputs.size(), typed_res);
        end else begin
            foreach (step_results[r]) begin
                pending_outputs.insert(pending_outputs.size(), step_results[r]);
            end
        end
        @(negedge i_clk);
    endtask

    // Lowers valid, waits for every owed result, then lets the back end
    // finish any item that gives no result before the registers change.
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_outputs.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // The receiver stalls at random, except through the steady phase.
    always @(negedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(0, 99) < 24);
    end

    // ------------------------------------------------------------------------
    // Checking: each result taken by the receiver is matched against the
    // oldest one owed.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outputs.size() == 0) begin
                $error("result with none expected: sample_out=%0d last=%0b clipped=%0b",
                       o_sample_out, o_last, o_clipped);
                error_count++;
            end else begin
                oldest_output = pending_outputs.pop_front();
                results_checked++;
                if (o_clipped === 1'b1) clipped_seen++;
                if (o_sample_out !== oldest_output.sample_out) begin
                    $error("sample_out mismatch: expected %0d, actual %0d",
                           oldest_output.sample_out, o_sample_out);
                    error_count++;
                end
                if (o_last !== oldest_output.last) begin
                    $error("last mismatch: expected %0b, actual %0b",
                           oldest_output.last, o_last);
                    error_count++;
                end
                if (o_clipped !== oldest_output.clipped) begin
                    $error("clipped mismatch: expected %0b, actual %0b",
                           oldest_output.clipped, o_clipped);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run if no item moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles, %0d results still owed",
                     quiet_cycles, pending_outputs.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        int                         row, ph, n, pick;
        logic signed [SAMPLE_W-1:0] smp;

        // Predictor state after reset. The taps stay undefined in the block
        // until loaded; no sample reaches a tap before it has been written.
        up_reg      = 7'd1;
        down_reg    = 7'd1;
        taps_reg    = 9'd256;
        newest_slot = 0;
        next_phase  = 0;
        foreach (sample_hist[i]) sample_hist[i] = '0;
        foreach (tap_mem[i]) tap_mem[i] = '0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset factors and a single tap.
        write_register(REG_TAP_COUNT, 9'd1);
        for (row = 0; row < N_DIRECTED; row++) begin
            send_item(directed_rows[row].cmd, directed_rows[row].sample_in,
                      directed_rows[row].coef_index, directed_rows[row].coef_value,
                      directed_rows[row].has_typed, directed_rows[row].typed_out,
                      directed_rows[row].typed_clip);
        end

        // Load every tap, so that any tap count may be used from here on.
        for (row = 0; row < TAPS_MAX; row++) begin
            send_item(CMD_COEF_WRITE, SAMPLE_W'($urandom), row[COEF_IDX_W-1:0],
                      random_coef(), 1'b0, '0, 1'b0);
        end

        // Random part. The phase offset carries over from one setting to the
        // next, so every change of factors lands in the middle of the stream.
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain_and_settle();
            no_idle = (ph == STEADY_PHASE);
            write_register(REG_UP_FACTOR, PHASE_UP[ph]);
            write_register(REG_DOWN_FACTOR, PHASE_DOWN[ph]);
            write_register(REG_TAP_COUNT, PHASE_TAPS[ph]);
            // A write to the undecoded index must leave all settings alone.
            if (ph == 3) write_register(REG_UNUSED, CFG_DATA_W'($urandom));
            for (n = 0; n < PHASE_ITEMS[ph]; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    send_item(CMD_COEF_WRITE, SAMPLE_W'($urandom), COEF_IDX_W'($urandom),
                              random_coef(), 1'b0, '0, 1'b0);
                end else begin
                    if (pick < 20) smp = 16'sh7FFF;
                    else if (pick < 25) smp = 16'sh8000;
                    else smp = SAMPLE_W'($urandom);
                    send_item(CMD_SAMPLE, smp, COEF_IDX_W'($urandom),
                              COEF_W'($urandom), 1'b0, '0, 1'b0);
                end
            end
        end
        drain_and_settle();
        no_idle = 1'b0;

        $display("Covered %0d input items (%0d coefficient loads) over %0d factor settings,",
                 items_accepted, coef_loads, N_PHASES + 1);
        $display("and checked %0d resampled outputs, %0d of them saturated.",
                 results_checked, clipped_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
